// ===== rtl/core/brc_pkg.sv =====
// Shared types and constants for the barometer reading compensation block.
package brc_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_TEMP_TRIM  = 2'd0;
  localparam logic [1:0] REG_PRES_FIRST = 2'd1;
  localparam logic [1:0] REG_PRES_SECOND = 2'd2;
  localparam logic [1:0] REG_PRES_THIRD = 2'd3;

  localparam int CFG_W = 48;

  // input commands
  localparam logic CMD_TEMP = 1'b0;
  localparam logic CMD_PRES = 1'b1;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;
  localparam logic signed [63:0] TEMP_HALF = 64'sd1 <<< 39;
  localparam logic signed [63:0] PRES_HALF = 64'sd1 <<< 17;

  // decoded trim words (P1 and P2 already offset by -2^14)
  typedef struct packed {
    logic        [15:0] t1;
    logic        [15:0] t2;
    logic signed [7:0]  t3;
    logic signed [16:0] p1;
    logic signed [16:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic        [15:0] p5;
    logic        [15:0] p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } trim_t;

  // stage 1: first products
  typedef struct packed {
    logic               cmd;
    logic signed [24:0] rs;
    logic signed [15:0] t;
    logic signed [31:0] tsq;
    logic        [47:0] r2;
    logic signed [40:0] rt;
    logic signed [40:0] rp9;
    logic signed [41:0] rp1;
    logic signed [32:0] p2t;
    logic signed [32:0] p6t;
    logic signed [42:0] dt2;
    logic signed [49:0] dd;
  } s1_t;

  // stage 2: second products and first partial sum
  typedef struct packed {
    logic               cmd;
    logic signed [24:0] rs;
    logic signed [46:0] tcb;
    logic signed [39:0] p7tsq;
    logic signed [39:0] p3tsq;
    logic signed [63:0] rp2t;
    logic signed [63:0] r2p9;
    logic signed [63:0] r2t;
    logic        [53:0] cube;
    logic signed [42:0] dt2;
    logic signed [57:0] dd3;
    logic signed [63:0] ps;
  } s2_t;

  // stage 3
  typedef struct packed {
    logic               cmd;
    logic signed [24:0] rs;
    logic signed [63:0] p8tcb;
    logic signed [41:0] p4s;
    logic signed [63:0] rp3;
    logic signed [63:0] r2t10;
    logic signed [63:0] cube11;
    logic signed [63:0] ps;
    logic signed [23:0] tval;
  } s3_t;

  // stage 4
  typedef struct packed {
    logic               cmd;
    logic signed [63:0] rp4;
    logic signed [63:0] ps;
    logic signed [23:0] tval;
  } s4_t;

endpackage

// ===== rtl/core/brc_trim_regs.sv =====
// Trim word registers and field decode.
module brc_trim_regs
  import brc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output trim_t            trim
);

  logic [39:0] temp_trim;
  logic [47:0] pres_first;
  logic [47:0] pres_second;
  logic [31:0] pres_third;

  // register writes, masked to width
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim   <= '0;
      pres_first  <= '0;
      pres_second <= '0;
      pres_third  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEMP_TRIM:   temp_trim   <= cfg_data[39:0];
        REG_PRES_FIRST:  pres_first  <= cfg_data[47:0];
        REG_PRES_SECOND: pres_second <= cfg_data[47:0];
        REG_PRES_THIRD:  pres_third  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // field decode
  always_comb begin
    trim.t1  = temp_trim[15:0];
    trim.t2  = temp_trim[31:16];
    trim.t3  = $signed(temp_trim[39:32]);
    trim.p1  = 17'($signed(pres_first[15:0])) - 17'sd16384;
    trim.p2  = 17'($signed(pres_first[31:16])) - 17'sd16384;
    trim.p3  = $signed(pres_first[39:32]);
    trim.p4  = $signed(pres_first[47:40]);
    trim.p5  = pres_second[15:0];
    trim.p6  = pres_second[31:16];
    trim.p7  = $signed(pres_second[39:32]);
    trim.p8  = $signed(pres_second[47:40]);
    trim.p9  = $signed(pres_third[15:0]);
    trim.p10 = $signed(pres_third[23:16]);
    trim.p11 = $signed(pres_third[31:24]);
  end

endmodule

// ===== rtl/core/brc_front.sv =====
// Pipeline stages 1 and 2: leading products of both polynomials.
module brc_front
  import brc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  logic               command,
  input  logic [23:0]        raw_sample,
  input  logic signed [15:0] temperature,
  input  trim_t              trim,
  output logic               v2,
  output s2_t                s2
);

  logic v1;
  s1_t  s1;
  s1_t  s1_next;
  s2_t  s2_next;
  logic signed [24:0] rs;
  logic signed [25:0] d;

  // stage 1 products
  always_comb begin
    rs = $signed({1'b0, raw_sample});
    d  = $signed({2'b00, raw_sample}) - $signed({2'b00, trim.t1, 8'h00});
    s1_next.cmd = command;
    s1_next.rs  = rs;
    s1_next.t   = temperature;
    s1_next.tsq = temperature * temperature;
    s1_next.r2  = 48'(raw_sample) * 48'(raw_sample);
    s1_next.rt  = rs * temperature;
    s1_next.rp9 = rs * trim.p9;
    s1_next.rp1 = rs * trim.p1;
    s1_next.p2t = trim.p2 * temperature;
    s1_next.p6t = $signed({1'b0, trim.p6}) * temperature;
    s1_next.dt2 = d * $signed({1'b0, trim.t2});
    s1_next.dd  = d * d;
  end

  // stage 2 products and first partial sum
  always_comb begin
    s2_next.cmd   = s1.cmd;
    s2_next.rs    = s1.rs;
    s2_next.tcb   = s1.tsq * s1.t;
    s2_next.p7tsq = trim.p7 * s1.tsq;
    s2_next.p3tsq = trim.p3 * s1.tsq;
    s2_next.rp2t  = s1.rs * s1.p2t;
    s2_next.r2p9  = s1.rs * s1.rp9;
    s2_next.r2t   = s1.rs * s1.rt;
    s2_next.cube  = 54'((64'(s1.r2[47:8]) * 64'(s1.rs[23:0])) >> 10);
    s2_next.dt2   = s1.dt2;
    s2_next.dd3   = s1.dd * trim.t3;
    s2_next.ps    = (64'($signed({1'b0, trim.p5})) <<< 27)
                  + (64'(s1.p6t) <<< 10)
                  + (64'(s1.rp1) <<< 4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
    end
  end

endmodule

// ===== rtl/core/brc_back.sv =====
// Pipeline stages 3 to 5: remaining products, sums, rounding and clipping.
module brc_back
  import brc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               v2,
  input  s2_t                s2,
  input  trim_t              trim,
  output logic               out_valid,
  output logic signed [31:0] compensated_value,
  output logic               saturated
);

  logic v3;
  logic v4;
  s3_t  s3;
  s3_t  s3_next;
  s4_t  s4;
  s4_t  s4_next;
  logic signed [63:0] tn;
  logic signed [63:0] p4tcb;
  logic signed [63:0] psum;
  logic signed [63:0] val;
  logic signed [31:0] value_next;
  logic               sat_next;

  // stage 3: third products, temperature result
  always_comb begin
    tn    = (64'(s2.dt2) <<< 18) + 64'(s2.dd3) + TEMP_HALF;
    p4tcb = trim.p4 * s2.tcb;
    s3_next.cmd    = s2.cmd;
    s3_next.rs     = s2.rs;
    s3_next.p8tcb  = trim.p8 * s2.tcb;
    s3_next.p4s    = 42'(p4tcb >>> 13);
    s3_next.rp3    = s2.rs * s2.p3tsq;
    s3_next.r2t10  = (s2.r2t >>> 16) * trim.p10;
    s3_next.cube11 = $signed({1'b0, s2.cube}) * trim.p11;
    s3_next.ps     = s2.ps + 64'(s2.p7tsq) + (s2.rp2t >>> 13) + (s2.r2p9 >>> 24);
    s3_next.tval   = 24'(tn >>> 40);
  end

  // stage 4: last product, partial sum
  always_comb begin
    s4_next.cmd  = s3.cmd;
    s4_next.rp4  = s3.rs * s3.p4s;
    s4_next.ps   = s3.ps + (s3.p8tcb >>> 15) + (s3.rp3 >>> 24)
                 + (s3.r2t10 >>> 16) + (s3.cube11 >>> 23);
    s4_next.tval = s3.tval;
  end

  // stage 5: final sum, rounding, select and clip
  always_comb begin
    psum = s4.ps + (s4.rp4 >>> 24) + PRES_HALF;
    if (s4.cmd == CMD_PRES) begin
      val = psum >>> 18;
    end else begin
      val = 64'(s4.tval);
    end
    if (val > SAT_MAX) begin
      value_next = 32'(SAT_MAX);
      sat_next   = 1'b1;
    end else if (val < SAT_MIN) begin
      value_next = 32'(SAT_MIN);
      sat_next   = 1'b1;
    end else begin
      value_next = 32'(val);
      sat_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3                <= s3_next;
      s4                <= s4_next;
      compensated_value <= value_next;
      saturated         <= sat_next;
    end
  end

endmodule

// ===== rtl/core/barometer_reading_compensation_top.sv =====
// Top level of the barometer reading compensation block.
//
// Input channel: in_valid / in_stall carry one word of command, raw_sample
// and temperature. Command 0 returns temperature in 1/256 degC, command 1
// returns pressure in 1/64 Pa computed from the supplied temperature.
// Output channel: out_valid / out_stall carry compensated_value and the
// saturated flag, one result word per input word, in order.
// Trim words are written through cfg_write / cfg_index / cfg_data while the
// pipeline is empty.
// There are five register stages; the first loads when a word is accepted.
// Throughput: one word per cycle while the output is not stalled.
// Reset clears the trim registers and all stage valid bits.
// When the receiver stalls a valid output, the whole pipeline holds and
// in_stall is raised; no word is lost or repeated.
module barometer_reading_compensation_top
  import brc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [23:0]        raw_sample,
  input  logic signed [15:0] temperature,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] compensated_value,
  output logic               saturated,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  trim_t trim;
  s2_t   s2;
  logic  v2;
  logic  en;

  // pipeline advances unless the output word is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  brc_trim_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .trim      (trim)
  );

  brc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (in_valid),
    .command     (command),
    .raw_sample  (raw_sample),
    .temperature (temperature),
    .trim        (trim),
    .v2          (v2),
    .s2          (s2)
  );

  brc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .en                (en),
    .v2                (v2),
    .s2                (s2),
    .trim              (trim),
    .out_valid         (out_valid),
    .compensated_value (compensated_value),
    .saturated         (saturated)
  );

endmodule

// ===== sim/barometer_reading_compensation_top_tb.sv =====
// Self-checking testbench for the barometer reading compensation block.
`timescale 1ns / 100ps

module barometer_reading_compensation_top_tb;
  import brc_pkg::*;

  typedef struct {
    logic               cmd;
    logic [23:0]        raw;
    logic signed [15:0] temp;
  } sample_t;

  typedef struct {
    logic signed [31:0] value;
    logic               sat;
  } reading_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               command;
  logic [23:0]        raw_sample;
  logic signed [15:0] temperature;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] compensated_value;
  logic               saturated;
  logic               cfg_write;
  logic [1:0]         cfg_index;
  logic [CFG_W-1:0]   cfg_data;

  // local copy of the trim words
  logic [39:0] temp_trim;
  logic [47:0] pres_first;
  logic [47:0] pres_second;
  logic [31:0] pres_third;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int       errors;
  int       checked;
  int       temp_count;
  int       pres_count;
  logic     took;
  logic     quiet;
  int       send_gap;
  int       stall_gap;

  barometer_reading_compensation_top dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // temperature in 1/256 degC
  function automatic longint compensate_temp(logic [23:0] raw);
    longint t1, t2, t3, d, n;
    t1 = temp_trim[15:0];
    t2 = temp_trim[31:16];
    t3 = $signed(temp_trim[39:32]);
    d = longint'(raw) - t1 * 256;
    n = d * t2 * 262144 + d * d * t3;
    return (n + (64'sd1 <<< 39)) >>> 40;
  endfunction

  // pressure in 1/64 Pa, terms summed in 2^-24 Pa
  function automatic longint compensate_pres(logic [23:0] raw, logic signed [15:0] temp);
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
    longint r, t, tsq, tcb, total;
    longint unsigned ru, r2, cube;
    p1 = longint'($signed(pres_first[15:0])) - 16384;
    p2 = longint'($signed(pres_first[31:16])) - 16384;
    p3 = $signed(pres_first[39:32]);
    p4 = $signed(pres_first[47:40]);
    p5 = pres_second[15:0];
    p6 = pres_second[31:16];
    p7 = $signed(pres_second[39:32]);
    p8 = $signed(pres_second[47:40]);
    p9 = $signed(pres_third[15:0]);
    p10 = $signed(pres_third[23:16]);
    p11 = $signed(pres_third[31:24]);
    ru = raw;
    r = raw;
    t = temp;
    r2 = ru * ru;
    tsq = t * t;
    tcb = tsq * t;
    total = p5 * 134217728;
    total += p6 * t * 1024;
    total += p7 * tsq;
    total += (p8 * tcb) >>> 15;
    total += r * p1 * 16;
    total += (r * p2 * t) >>> 13;
    total += (r * p3 * tsq) >>> 24;
    total += (r * ((p4 * tcb) >>> 13)) >>> 24;
    total += (longint'(r2) * p9) >>> 24;
    total += (((longint'(r2) * t) >>> 16) * p10) >>> 16;
    cube = ((r2 >> 8) * ru) >> 10;
    total += (longint'(cube) * p11) >>> 23;
    return (total + (64'sd1 <<< 17)) >>> 18;
  endfunction

  function automatic reading_t predict_reading(sample_t s);
    reading_t res;
    longint   v;
    v = (s.cmd == CMD_TEMP) ? compensate_temp(s.raw) : compensate_pres(s.raw, s.temp);
    res.sat = 1'b0;
    if (v > 64'sd2147483647) begin
      v = 64'sd2147483647;
      res.sat = 1'b1;
    end else if (v < -64'sd2147483648) begin
      v = -64'sd2147483648;
      res.sat = 1'b1;
    end
    res.value = v[31:0];
    return res;
  endfunction

  // sender: one word per handshake, random idle bursts between words
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !took) begin
      in_valid <= 1'b1;
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_samples.size() > 0) begin
      sample_t s;
      s = pending_samples.pop_front();
      command <= s.cmd;
      raw_sample <= s.raw;
      temperature <= s.temp;
      in_valid <= 1'b1;
      if (!quiet && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 15);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver stall bursts
  always @(negedge clk) begin
    if (quiet || rst) begin
      out_stall <= 1'b0;
    end else if (stall_gap > 0) begin
      out_stall <= 1'b1;
      stall_gap <= stall_gap - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_gap <= $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // input acceptance: work out the expected reading
  always @(posedge clk) begin
    took <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      sample_t s;
      s.cmd = command;
      s.raw = raw_sample;
      s.temp = temperature;
      expected_readings.push_back(predict_reading(s));
      if (command == CMD_TEMP) temp_count++;
      else pres_count++;
    end
  end

  // output check against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      reading_t exp_r;
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected word value=%0d sat=%0b", $time,
                 compensated_value, saturated);
        errors++;
      end else begin
        exp_r = expected_readings.pop_front();
        checked++;
        if (compensated_value !== exp_r.value) begin
          $display("%0t: value expected %0d actual %0d", $time, exp_r.value,
                   compensated_value);
          errors++;
        end
        if (saturated !== exp_r.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, exp_r.sat,
                   saturated);
          errors++;
        end
      end
    end
  end

  task automatic write_trim(logic [1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_TEMP_TRIM:   temp_trim = data[39:0];
      REG_PRES_FIRST:  pres_first = data[47:0];
      REG_PRES_SECOND: pres_second = data[47:0];
      default:         pres_third = data[31:0];
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic write_all_trims(logic [CFG_W-1:0] a, logic [CFG_W-1:0] b,
                                 logic [CFG_W-1:0] c, logic [CFG_W-1:0] d);
    write_trim(REG_TEMP_TRIM, a);
    write_trim(REG_PRES_FIRST, b);
    write_trim(REG_PRES_SECOND, c);
    write_trim(REG_PRES_THIRD, d);
  endtask

  function automatic logic [CFG_W-1:0] rand_word();
    return CFG_W'({$urandom(), $urandom()});
  endfunction

  task automatic add_sample(logic cmd, logic [23:0] raw, logic signed [15:0] temp);
    sample_t s;
    s.cmd = cmd;
    s.raw = raw;
    s.temp = temp;
    pending_samples.push_back(s);
  endtask

  task automatic add_random(int n);
    logic signed [15:0] tv;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) tv = 16'($urandom());
      else tv = 16'(int'($urandom_range(0, 46080)) - 20480);
      add_sample(1'($urandom_range(0, 1)), 24'($urandom()), tv);
    end
  endtask

  // sender pauses here until every expected word has come back
  task automatic drain();
    while (pending_samples.size() > 0 || in_valid || expected_readings.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_directed();
    add_sample(CMD_TEMP, 24'h000000, 16'sd0);
    add_sample(CMD_TEMP, 24'hFFFFFF, 16'sd0);
    add_sample(CMD_TEMP, 24'h6B8000, -16'sd32768);
    add_sample(CMD_TEMP, 24'h800000, 16'sd32767);
    add_sample(CMD_PRES, 24'h000000, 16'sd0);
    add_sample(CMD_PRES, 24'hFFFFFF, 16'sd0);
    add_sample(CMD_PRES, 24'hFFFFFF, 16'sd25600);
    add_sample(CMD_PRES, 24'hFFFFFF, -16'sd20480);
    add_sample(CMD_PRES, 24'h000000, 16'sd32767);
    add_sample(CMD_PRES, 24'hFFFFFF, -16'sd32768);
    add_sample(CMD_PRES, 24'h5A5A5A, 16'sd6400);
    add_sample(CMD_PRES, 24'hA5A5A5, -16'sd1);
  endtask

  initial begin
    errors = 0;
    checked = 0;
    temp_count = 0;
    pres_count = 0;
    quiet = 1'b0;
    temp_trim = '0;
    pres_first = '0;
    pres_second = '0;
    pres_third = '0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_TEMP_TRIM;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset trims all zero
    run_directed();
    drain();
    // typical trims
    write_all_trims(48'h00_CE_66_43_6B70, 48'h0000_F3_2F_1A04, 48'h00FB_035A_3A2C,
                    48'hC4_F2_4E20);
    run_directed();
    add_random(60);
    drain();
    // all ones, upper data bits beyond each width set too
    write_all_trims('1, '1, '1, '1);
    run_directed();
    add_random(40);
    drain();
    // most negative signed trims, maximum unsigned ones
    write_all_trims(48'h80_FFFF_FFFF, 48'h80_80_8000_8000, 48'h80_80_FFFF_FFFF,
                    48'h80_80_8000);
    run_directed();
    add_random(40);
    drain();
    // random trims
    for (int ph = 0; ph < 4; ph++) begin
      write_all_trims(rand_word(), rand_word(), rand_word(), rand_word());
      add_random(45);
      drain();
    end
    // last stretch without idling
    quiet = 1'b1;
    write_all_trims(rand_word(), rand_word(), rand_word(), rand_word());
    add_random(40);
    drain();

    $display("covered %0d temperature and %0d pressure words, %0d checked,", temp_count,
             pres_count, checked);
    $display("over zero, typical, extreme and random trim settings");
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("timeout with %0d words outstanding", expected_readings.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
